// File: hw/rtl/gfrs_pkg.sv
package gfrs_pkg;

  localparam int MAX_CHECK_BYTES = 32;
  // the output index field is five bits wide, so no more than 32 cells
  localparam int NUM_CELLS = (MAX_CHECK_BYTES < 32) ? MAX_CHECK_BYTES : 32;
  localparam int LEN_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COEFF_WORDS = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_ECC_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GEN_COEFFS_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GEN_COEFFS_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GEN_COEFFS_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GEN_COEFFS_3 = 3'd4;

  localparam logic [LEN_W-1:0] ECC_LENGTH_RESET = 6'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } gfrs_in_t;

  typedef struct packed {
    logic [7:0] check_byte;
    logic [4:0] check_index;
    logic       last_check;
  } gfrs_out_t;

  // per-cycle commands shared by every cell of the row
  typedef struct packed {
    logic step;   // a message byte enters the remainder
    logic clear;  // that byte ends the message
    logic load;   // copy the updated remainder into the output row
    logic shift;  // output row moves one cell toward the head
  } gfrs_ctrl_t;

  // multiply in GF(256), field polynomial 0x11D
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] acc;
    x = a;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1D) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// File: hw/rtl/gfrs_cell.sv
module gfrs_cell (
  input  logic               clk,
  input  logic               rst,
  input  gfrs_pkg::gfrs_ctrl_t ctrl,
  input  logic [7:0]         fb,
  input  logic [7:0]         coeff,
  input  logic               active,
  input  logic               tail,
  input  logic [7:0]         rem_in,
  input  logic [7:0]         drain_in,
  output logic [7:0]         rem,
  output logic [7:0]         drain
);
  import gfrs_pkg::*;

  logic [7:0] upd;
  logic [7:0] rem_next;

  // tail cell of the active length takes the bare product
  assign upd = (tail ? 8'h00 : rem_in) ^ gf_mul(fb, coeff);
  assign rem_next = active ? upd : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 8'h00;
    end else if (ctrl.step) begin
      rem <= ctrl.clear ? 8'h00 : rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drain <= rem_next;
    end else if (ctrl.shift) begin
      drain <= drain_in;
    end
  end

endmodule

// File: hw/rtl/gf256_rs_remainder_top.sv
// Reed-Solomon check byte generator over GF(256), field polynomial 0x11D. Message
// bytes enter highest order first, one per clock, into a row of 32 remainder cells
// whose active cells update in parallel; the request that carries message_end loads the n
// check bytes (n = ecc_length, 0 read as 1, capped at 32) into an output row and
// clears the remainder. Check bytes leave one per clock while out_ready is high, highest
// order first, while the next message streams in; a request that ends a message waits only
// while check bytes of the previous message are still queued, so a run of n check bytes
// sets the minimum spacing between message ends. Write ecc_length and the
// generator words only while the block is idle.
module gf256_rs_remainder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gfrs_pkg::gfrs_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gfrs_pkg::gfrs_out_t               out_data,
  input  logic                              cfg_write,
  input  logic [gfrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gfrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gfrs_pkg::*;

  logic [LEN_W-1:0]      ecc_length;
  logic [CFG_DATA_W-1:0] gen_coeffs [COEFF_WORDS];
  logic [LEN_W-1:0]      n_eff;
  logic [LEN_W-1:0]      count;
  logic [4:0]            index;
  logic [7:0]            rem_q   [NUM_CELLS];
  logic [7:0]            drain_q [NUM_CELLS];
  logic [7:0]            fb;
  logic                  in_acc;
  logic                  out_acc;
  gfrs_ctrl_t            ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_length <= ECC_LENGTH_RESET;
      for (int w = 0; w < COEFF_WORDS; w++) gen_coeffs[w] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ECC_LENGTH:   ecc_length <= cfg_data[LEN_W-1:0];
        REG_GEN_COEFFS_0: gen_coeffs[0] <= cfg_data;
        REG_GEN_COEFFS_1: gen_coeffs[1] <= cfg_data;
        REG_GEN_COEFFS_2: gen_coeffs[2] <= cfg_data;
        REG_GEN_COEFFS_3: gen_coeffs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ecc_length == '0) n_eff = LEN_W'(1);
    else if (ecc_length > LEN_W'(NUM_CELLS)) n_eff = LEN_W'(NUM_CELLS);
    else n_eff = ecc_length;
  end

  assign out_valid = (count != '0);
  assign out_acc   = out_valid && out_ready;
  // an ending request needs the output row free by the next edge
  assign in_ready  = !in_data.message_end || (count == '0) ||
                     ((count == LEN_W'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;
  assign fb        = in_data.data_byte ^ rem_q[0];

  assign ctrl = '{step:  in_acc,
                  clear: in_data.message_end,
                  load:  in_acc && in_data.message_end,
                  shift: out_acc};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [7:0] rem_in;
    logic [7:0] drain_in;
    if (i == NUM_CELLS - 1) begin : g_end
      assign rem_in   = 8'h00;
      assign drain_in = 8'h00;
    end else begin : g_mid
      assign rem_in   = rem_q[i+1];
      assign drain_in = drain_q[i+1];
    end

    gfrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .fb       (fb),
      .coeff    (gen_coeffs[i/8][(i%8)*8 +: 8]),
      .active   (LEN_W'(i) < n_eff),
      .tail     (LEN_W'(i) == n_eff - LEN_W'(1)),
      .rem_in   (rem_in),
      .drain_in (drain_in),
      .rem      (rem_q[i]),
      .drain    (drain_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      index <= '0;
    end else if (ctrl.load) begin
      count <= n_eff;
      index <= '0;
    end else if (out_acc) begin
      count <= count - LEN_W'(1);
      index <= index + 5'd1;
    end
  end

  assign out_data = '{check_byte:  drain_q[0],
                      check_index: index,
                      last_check:  (count == LEN_W'(1))};

endmodule

// File: hw/rtl/gfrs_checker.sv
module gfrs_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input gfrs_pkg::gfrs_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input gfrs_pkg::gfrs_out_t out_data
);
  import gfrs_pkg::*;

  // nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("check byte shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled check byte changed");

  // within a run the index steps by one
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_check |=>
      out_valid && (out_data.check_index == 5'($past(out_data.check_index) + 5'd1)))
    else $error("check index skipped");

  // after the last byte a new run starts at index zero or the output goes quiet
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_check |=>
      !out_valid || (out_data.check_index == 5'd0))
    else $error("run continued past last check byte");

  // an ending request is not taken while more than one check byte is queued
  a_end_gate: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.message_end && out_valid |->
      out_data.last_check && out_ready)
    else $error("message end accepted over a pending run");

endmodule

bind gf256_rs_remainder_top gfrs_checker u_gfrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
